// ===== design/clock_time_text_to_microseconds_top_assert.svh =====
// Assertion macros shared by the clock-time parser RTL.
// Depends on nothing; included by the top level only.
`ifndef CLOCK_TIME_TEXT_TO_MICROSECONDS_TOP_ASSERT_SVH
`define CLOCK_TIME_TEXT_TO_MICROSECONDS_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CTTU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CTTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cttu_pkg.sv =====
// Package for the clock-time text parser: widths, character codes,
// scale table and the record handed from the parse stage to the scale stage.
`timescale 1ns / 1ps

package cttu_pkg;

	localparam int TOTAL_W = 63;
	localparam int GROUP_W = 31;
	localparam int FDIG_W  = 3;
	localparam int US_W    = 20;
	localparam int CHAR_W  = 8;

	localparam logic [US_W-1:0]    US_PER_SEC = 20'd1000000;
	localparam logic [GROUP_W-1:0] GROUP_MAX  = 31'h7FFFFFFF;
	localparam logic [FDIG_W-1:0]  FRAC_LIMIT = 3'd6;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;

	// Finished text: whole seconds, last group and its decimal exponent.
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [GROUP_W-1:0] group;
		logic [FDIG_W-1:0]  expo;
	} fin_t;

	// Power of ten for a group scaled to microseconds.
	function automatic logic [US_W-1:0] pow10(input logic [FDIG_W-1:0] e);
		logic [US_W-1:0] r;
		unique case (e)
			3'd0:    r = 20'd1;
			3'd1:    r = 20'd10;
			3'd2:    r = 20'd100;
			3'd3:    r = 20'd1000;
			3'd4:    r = 20'd10000;
			3'd5:    r = 20'd100000;
			3'd6:    r = 20'd1000000;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/cttu_in_if.sv =====
// Character channel: one text byte per transfer, with an end-of-text mark.
// Depends on cttu_pkg for the character width.
`timescale 1ns / 1ps

interface cttu_in_if;
	import cttu_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== design/cttu_out_if.sv =====
// Result channel: one time in microseconds per transfer.
// Depends on cttu_pkg for the result width.
`timescale 1ns / 1ps

interface cttu_out_if;
	import cttu_pkg::*;
	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] time_us;

	modport source (output valid, output time_us, input ready);
	modport sink   (input valid, input time_us, output ready);
endinterface

// ===== design/cttu_parse.sv =====
// Parse stage: input register, running text state, and the finished-text
// register. Depends on cttu_pkg and cttu_in_if.
`timescale 1ns / 1ps

module cttu_parse import cttu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	cttu_in_if.sink char_in,
	output logic   fin_valid,
	input  logic   fin_ready,
	output fin_t   fin
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	logic [TOTAL_W-1:0] total_q;
	logic [GROUP_W-1:0] group_q;
	logic [FDIG_W-1:0]  fdig_q;
	logic               point_q;

	logic valid_s2;
	fin_t fin_s2;

	logic s2_free;
	logic s1_fire;

	logic               is_digit;
	logic [GROUP_W+3:0] grow;
	logic [TOTAL_W-1:0] sum;
	logic [TOTAL_W-1:0] total_n;
	logic [GROUP_W-1:0] group_n;
	logic [FDIG_W-1:0]  fdig_n;
	logic               point_n;
	fin_t               fin_n;

	// A character waits in s1 only when it ends a text and s2 is full.
	assign s2_free      = !valid_s2 || fin_ready;
	assign s1_fire      = valid_s1 && (!last_s1 || s2_free);
	assign char_in.ready = !valid_s1 || s1_fire;

	// Hold the incoming transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.valid && char_in.ready) begin
			char_s1 <= char_in.char_code;
			last_s1 <= char_in.last_char;
		end
	end

	// Next text state for the character in s1.
	always_comb begin
		is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
		grow     = ({4'b0, group_q} << 3) + ({4'b0, group_q} << 1)
			+ {{(GROUP_W){1'b0}}, char_s1[3:0]};
		sum      = total_q + {{(TOTAL_W-GROUP_W){1'b0}}, group_q};
		total_n  = total_q;
		group_n  = group_q;
		fdig_n   = fdig_q;
		point_n  = point_q;
		priority if (is_digit) begin
			// Drop digits past the sixth fraction digit.
			if (!(point_q && fdig_q >= FRAC_LIMIT)) begin
				group_n = (grow > {4'b0, GROUP_MAX}) ? GROUP_MAX : grow[GROUP_W-1:0];
				if (point_q) begin
					fdig_n = fdig_q + 3'd1;
				end
			end
		end else if (char_s1 == CH_COLON) begin
			total_n = (sum << 6) - (sum << 2);
			group_n = '0;
		end else if (char_s1 == CH_POINT) begin
			total_n = sum;
			group_n = '0;
			fdig_n  = '0;
			point_n = 1'b1;
		end else begin
			// Ignore any other character.
			point_n = point_q;
		end
		// Without a point the last group is whole seconds: scale by 10^6.
		fin_n.total = total_n;
		fin_n.group = group_n;
		fin_n.expo  = point_n ? (FRAC_LIMIT - fdig_n) : FRAC_LIMIT;
	end

	// Advance the text state; clear it after the final character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			group_q <= '0;
			fdig_q  <= '0;
			point_q <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				total_q <= '0;
				group_q <= '0;
				fdig_q  <= '0;
				point_q <= 1'b0;
			end else begin
				total_q <= total_n;
				group_q <= group_n;
				fdig_q  <= fdig_n;
				point_q <= point_n;
			end
		end
	end

	// Hold a finished text until the scale stage takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_fire && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_fire && last_s1) begin
			fin_s2 <= fin_n;
		end
	end

	assign fin_valid = valid_s2;
	assign fin       = fin_s2;

endmodule

// ===== design/cttu_scale.sv =====
// Scale stage: multiply the finished text into microseconds and hold the
// result for the output channel. Depends on cttu_pkg and cttu_out_if.
`timescale 1ns / 1ps

module cttu_scale import cttu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fin_valid,
	output logic        fin_ready,
	input  fin_t        fin,
	cttu_out_if.source  time_out
);

	localparam int LO_W   = 32;
	localparam int HI_W   = TOTAL_W - LO_W;
	localparam int LOP_W  = LO_W + US_W;
	localparam int HIP_W  = HI_W + US_W;
	localparam int FRAC_W = GROUP_W + US_W;

	logic              valid_s3;
	logic [LOP_W-1:0]  lo_s3;
	logic [HI_W-1:0]   hi_s3;
	logic [FRAC_W-1:0] frac_s3;

	logic               out_valid_q;
	logic [TOTAL_W-1:0] time_us_q;

	logic               out_free;
	logic               s3_free;
	logic [LOP_W-1:0]   lo_prod;
	logic [HIP_W-1:0]   hi_prod;
	logic [FRAC_W-1:0]  frac_prod;
	logic [TOTAL_W-1:0] time_sum;

	assign out_free  = !out_valid_q || time_out.ready;
	assign s3_free   = !valid_s3 || out_free;
	assign fin_ready = s3_free;

	// Split the seconds product in two halves; scale the last group.
	always_comb begin
		lo_prod   = {{US_W{1'b0}}, fin.total[LO_W-1:0]} * {{LO_W{1'b0}}, US_PER_SEC};
		hi_prod   = {{US_W{1'b0}}, fin.total[TOTAL_W-1:LO_W]} * {{HI_W{1'b0}}, US_PER_SEC};
		frac_prod = {{US_W{1'b0}}, fin.group} * {{GROUP_W{1'b0}}, pow10(fin.expo)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && fin_valid) begin
			lo_s3   <= lo_prod;
			hi_s3   <= hi_prod[HI_W-1:0];
			frac_s3 <= frac_prod;
		end
	end

	// Sum the partial products modulo 2^63.
	assign time_sum = {{(TOTAL_W-LOP_W){1'b0}}, lo_s3}
		+ {hi_s3, {LO_W{1'b0}}}
		+ {{(TOTAL_W-FRAC_W){1'b0}}, frac_s3};

	// Hold the result until the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			time_us_q <= time_sum;
		end
	end

	assign time_out.valid   = out_valid_q;
	assign time_out.time_us = time_us_q;

endmodule

// ===== design/clock_time_text_to_microseconds_top.sv =====
// Channel    Dir  Payload                       Transfer
// char_in    in   char_code[7:0], last_char     valid && ready
// time_out   out  time_us[62:0]                 valid && ready
//
// One character per cycle unless the input stalls; the text state updates in
// the cycle after a non-final character's transfer. The final character's
// result passes the input, finished-text, product and output registers.
// Reset clears all valid bits and the text state. Characters keep flowing
// while results wait; the input stalls only when every result stage is full.
// Top level of the clock-time text parser; depends on cttu_pkg,
// the channel interfaces, cttu_parse, cttu_scale and the assertion header.
`timescale 1ns / 1ps
`include "clock_time_text_to_microseconds_top_assert.svh"

module clock_time_text_to_microseconds_top import cttu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cttu_in_if.sink    char_in,
	cttu_out_if.source time_out
);

	logic fin_valid;
	logic fin_ready;
	fin_t fin;

	// Character parsing and running state.
	cttu_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_in),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin       (fin)
	);

	// Conversion to microseconds.
	cttu_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin       (fin),
		.time_out  (time_out)
	);

	`CTTU_ASSERT_NEXT(a_fin_hold, clk, arst_n, fin_valid && !fin_ready, fin_valid && $stable(fin), "finished text changed while stalled")
	`CTTU_ASSERT_IMP(a_fin_expo, clk, arst_n, fin_valid, fin.expo <= FRAC_LIMIT, "fraction exponent out of range")
	`CTTU_ASSERT_IMP(a_stall_cause, clk, arst_n, !char_in.ready, time_out.valid, "input stalled with no result pending")

endmodule
